>>> hw/rtl/ulps_pkg.sv
// ----------------------------------------------------------------------------
// ulps_pkg
// Shared beat layouts, field widths and codes for the unsorted list
// priority store.
// ----------------------------------------------------------------------------
package ulps_pkg;

   // Fixed field widths of the channels
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int CAP_W    = 7;

   // Capacity limit after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ADD       = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_MAX = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_AT = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY_MIN = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

   // Request beat
   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] result_value;
      logic [COUNT_W-1:0]        count_after;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

endpackage

>>> hw/rtl/ulps_if.sv
// ----------------------------------------------------------------------------
// ulps_if
// Valid/ready channels of the store: request, response and capacity write.
// ----------------------------------------------------------------------------
interface ulps_req_if;
   logic              valid;
   logic              ready;
   ulps_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ulps_rsp_if;
   logic              valid;
   logic              ready;
   ulps_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ulps_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ulps_pkg::CAP_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ulps_mem.sv
// ----------------------------------------------------------------------------
// ulps_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ulps_mem #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int AW          = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] store_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // Write entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read entry, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ulps_ctrl.sv
// ----------------------------------------------------------------------------
// ulps_ctrl
// Sequencer of the store: appends, scans the entry memory for the maximum or
// minimum, closes gaps by moving later entries down, and holds the result.
// ----------------------------------------------------------------------------
module ulps_ctrl #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int AW          = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ulps_pkg::CAP_W-1:0] cap_limit,
   ulps_req_if.sink                   req_chan,
   ulps_rsp_if.source                 rsp_chan,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [VALUE_WIDTH-1:0]     mem_wdata,
   output logic                       mem_re,
   output logic [AW-1:0]              mem_raddr,
   input  logic [VALUE_WIDTH-1:0]     mem_rdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > ulps_pkg::CAP_W) ? CW : ulps_pkg::CAP_W;
   localparam int PW = (CW > ulps_pkg::POS_W) ? CW : ulps_pkg::POS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [ulps_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                   rd_idx_ff, rd_idx_in;
   logic                            first_ff, first_in;
   logic [AW-1:0]                   best_idx_ff, best_idx_in;
   logic [VALUE_WIDTH-1:0]          best_val_ff, best_val_in;
   logic [ulps_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   ulps_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic full_now;
   logic take_new;
   logic rsp_free;

   // Store counts as full at the capacity limit or at the memory depth
   assign full_now = (LW'(cnt_ff) >= LW'(cap_limit)) || (cnt_ff >= CW'(DEPTH));

   // Keep the first read entry, then strictly better ones (earliest wins ties)
   assign take_new = first_ff
      || ((act_ff == ulps_pkg::ACT_REMOVE_MAX)
          && ($signed(mem_rdata) > $signed(best_val_ff)))
      || ((act_ff == ulps_pkg::ACT_QUERY_MIN)
          && ($signed(mem_rdata) < $signed(best_val_ff)));

   assign rsp_free = !rsp_vld_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      first_in    = first_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_waddr   = rd_idx_ff - AW'(1);
      mem_wdata   = mem_rdata;
      mem_re      = 1'b0;
      mem_raddr   = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in      = req_chan.data.action;
               status_in   = ulps_pkg::ST_OK;
               best_val_in = '0;
               first_in    = 1'b1;
               if (req_chan.data.action == ulps_pkg::ACT_ADD) begin
                  // Append at the end unless full
                  if (full_now) begin
                     status_in = ulps_pkg::ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = cnt_ff[AW-1:0];
                     mem_wdata = VALUE_WIDTH'($signed(req_chan.data.value));
                     cnt_in    = cnt_ff + CW'(1);
                  end
                  state_in = S_FINISH;
               end else if (cnt_ff == '0) begin
                  status_in = ulps_pkg::ST_EMPTY;
                  state_in  = S_FINISH;
               end else if (req_chan.data.action == ulps_pkg::ACT_REMOVE_AT) begin
                  if (PW'(req_chan.data.position) >= PW'(cnt_ff)) begin
                     status_in = ulps_pkg::ST_BAD_POS;
                     state_in  = S_FINISH;
                  end else begin
                     // Fetch the one entry, no further scan reads
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_chan.data.position);
                     rd_vld_in = 1'b1;
                     rd_idx_in = AW'(req_chan.data.position);
                     idx_in    = cnt_ff;
                     state_in  = S_SCAN;
                  end
               end else begin
                  // Start the scan at entry zero
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  rd_vld_in = 1'b1;
                  rd_idx_in = '0;
                  idx_in    = CW'(1);
                  state_in  = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Issue the next read while the previous one is compared
            if (idx_ff < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[AW-1:0];
               idx_in    = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               first_in = 1'b0;
               if (take_new) begin
                  best_idx_in = rd_idx_ff;
                  best_val_in = mem_rdata;
               end
               if (idx_ff >= cnt_ff) begin
                  if (act_ff == ulps_pkg::ACT_QUERY_MIN) begin
                     state_in = S_FINISH;
                  end else begin
                     idx_in   = CW'(best_idx_in) + CW'(1);
                     state_in = S_SHIFT;
                  end
               end
            end
         end

         S_SHIFT: begin
            // Move each later entry down by one place
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff - AW'(1);
               mem_wdata = mem_rdata;
            end
            if (idx_ff < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[AW-1:0];
               idx_in    = idx_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      if ((state_ff == S_FINISH) && rsp_free) begin
         rsp_vld_in               = 1'b1;
         rsp_data_in.status       = status_ff;
         rsp_data_in.result_value = ulps_pkg::VALUE_W'(best_val_ff);
         rsp_data_in.count_after  = ulps_pkg::COUNT_W'(cnt_ff);
         rsp_data_in.is_empty     = (cnt_ff == '0);
         rsp_data_in.is_full      = full_now;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      first_ff    <= first_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Count never passes the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // Count moves by at most one per item
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff == $past(cnt_ff))
                     || (cnt_ff == $past(cnt_ff) + CW'(1))
                     || (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("entry count jumped");

   // A shift write never targets below entry zero
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) && rd_vld_ff |-> rd_idx_ff != '0)
      else $error("shift read at entry zero");

   // A response appears only after the finishing step
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_vld_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response without finished item");

endmodule

>>> hw/rtl/unsorted_list_priority_store_top.sv
// ----------------------------------------------------------------------------
// unsorted_list_priority_store_top
// Bounded store of signed values in insertion order with add, remove-max,
// remove-at and query-min, built around one single-port-read entry memory.
// Add and every error: the finish state loads the response register, and the
// next request is taken in the same cycle that the result appears.
// Query-min: one memory read per entry.
// Remove-max scans then shifts, remove-at reads one entry then shifts; both
// use the one read and one write port of the entry memory.
// Reset clears the count and the handshake state; capacity limit resets to 64.
// ----------------------------------------------------------------------------
module unsorted_list_priority_store_top #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ulps_req_if.sink   req_chan,
   ulps_rsp_if.source rsp_chan,
   ulps_csr_if.sink   csr_chan
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ulps_pkg::CAP_W-1:0] cap_ff;
   logic [ulps_pkg::CAP_W-1:0] cap_in;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [VALUE_WIDTH-1:0]     mem_wdata;
   logic                       mem_re;
   logic [AW-1:0]              mem_raddr;
   logic [VALUE_WIDTH-1:0]     mem_rdata;

   // Capacity register, always ready for a beat
   assign csr_chan.ready = 1'b1;
   assign cap_in = csr_chan.valid ? csr_chan.data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ulps_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   ulps_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cap_limit (cap_ff),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   ulps_mem #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule
